>>> rtl/tcrms_pkg.sv
// ----------------------------------------------------------------------------
// tcrms_pkg
// Shared widths, constants, register codes and types of the two-channel RMS
// meter.
// ----------------------------------------------------------------------------
package tcrms_pkg;

  // Window of samples averaged per channel
  localparam int WINDOW_LENGTH = 20;
  localparam int POS_W         = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int RING_DEPTH    = 2 * WINDOW_LENGTH;
  localparam int RING_AW       = $clog2(RING_DEPTH);

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int ZERO_W   = 12;
  localparam int GAIN_W   = 16;
  localparam int DIFF_W   = 13;
  localparam int SCALED_W = 21;
  localparam int RMS_W    = 20;
  localparam int SUM_W    = 46;

  // Shared multiplier: signed SCALED_W x SCALED_W
  localparam int MUL_W  = SCALED_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int FRAC_W = 8;

  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (SCALED_W - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

  // Divide by WINDOW_LENGTH: DIV_BITS quotient bits per cycle
  localparam int DIV_BITS   = 8;
  localparam int DIV_CYCLES = (SUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_PAD_W  = DIV_CYCLES * DIV_BITS;
  localparam int REM_W      = $clog2(2 * WINDOW_LENGTH);
  localparam int CNT_W      = $clog2(DIV_CYCLES);

  // APB register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_VOLTAGE_GAIN = 2'd0,
    REG_CURRENT_ZERO = 2'd1,
    REG_CURRENT_GAIN = 2'd2
  } reg_idx_t;

  localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST = GAIN_W'(4352);
  localparam logic [ZERO_W-1:0] CURRENT_ZERO_RST = ZERO_W'(1650);
  localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST = GAIN_W'(19248);

  typedef struct packed {
    logic [GAIN_W-1:0] voltage_gain_q8;
    logic [ZERO_W-1:0] current_zero_mv;
    logic [GAIN_W-1:0] current_gain_q8;
  } cfg_t;

  typedef struct packed {
    logic                       rd_en;
    logic                       wr_en;
    logic                       ch;
    logic [POS_W-1:0]           pos;
    logic signed [SCALED_W-1:0] wr_data;
  } ring_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_SAT,
    S_SQ_NEW,
    S_ACC,
    S_DIV,
    S_SQRT,
    S_DONE
  } core_state_t;

endpackage

>>> rtl/tcrms_if.sv
// ----------------------------------------------------------------------------
// tcrms_if
// Valid/ready channels: input samples and result items.
// ----------------------------------------------------------------------------
interface tcrms_in_if import tcrms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                channel;
  logic [SAMPLE_W-1:0] sample_mv;

  modport source (output valid, output channel, output sample_mv, input ready);
  modport sink   (input valid, input channel, input sample_mv, output ready);
endinterface

interface tcrms_out_if import tcrms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       channel_out;
  logic signed [SCALED_W-1:0] scaled_value;
  logic [RMS_W-1:0]           rms_value;

  modport source (output valid, output channel_out, output scaled_value, output rms_value,
                  input ready);
  modport sink   (input valid, input channel_out, input scaled_value, input rms_value,
                  output ready);
endinterface

>>> rtl/two_channel_sliding_rms_meter.sv
// ----------------------------------------------------------------------------
// two_channel_sliding_rms_meter
// Scales voltage/current samples and reports the sliding-window RMS of each
// channel.
// ----------------------------------------------------------------------------
// One item is handled at a time. After acceptance it goes through scaling,
// squaring and sum update on one shared signed 21x21 multiplier, a divide of
// the 46-bit sum of squares by the window at 8 quotient bits a cycle, 23
// iterations of the bit-serial square root on a 46-bit compare/subtract and
// a hand-off into the output register; the next item is accepted after that
// hand-off. The square root loop is the longest of these steps. A finished
// result sits in an output register; the block takes a new sample while it
// waits, and stalls before hand-off only if the previous result is still
// untaken. Both channel rings share one memory with per-entry valid bits, so
// they read as zero after reset with no clearing pass. Registers (APB, byte
// addresses): 0x0 voltage gain Q8.8, 0x4 current zero offset in mV, 0x8
// current gain Q8.8; write them only while the block is idle.
// ----------------------------------------------------------------------------
module two_channel_sliding_rms_meter import tcrms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tcrms_in_if.sink          in_chan,
  tcrms_out_if.source       out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t                       cfg;
  ring_req_t                  ring_req;
  logic signed [SCALED_W-1:0] old_value;

  // register file
  tcrms_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // last WINDOW_LENGTH scaled values of each channel
  tcrms_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (ring_req),
    .old_value (old_value)
  );

  // sequencer and shared arithmetic
  tcrms_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .ring_req  (ring_req),
    .old_value (old_value)
  );

endmodule

>>> rtl/tcrms_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcrms_cfg_regs
// APB register file: gains and current zero offset.
// ----------------------------------------------------------------------------
module tcrms_cfg_regs import tcrms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_VOLTAGE_GAIN: cfg_nxt.voltage_gain_q8 = cfg_pwdata[GAIN_W-1:0];
        REG_CURRENT_ZERO: cfg_nxt.current_zero_mv = cfg_pwdata[ZERO_W-1:0];
        REG_CURRENT_GAIN: cfg_nxt.current_gain_q8 = cfg_pwdata[GAIN_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VOLTAGE_GAIN: cfg_prdata = DATA_W'(cfg_r.voltage_gain_q8);
      REG_CURRENT_ZERO: cfg_prdata = DATA_W'(cfg_r.current_zero_mv);
      REG_CURRENT_GAIN: cfg_prdata = DATA_W'(cfg_r.current_gain_q8);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voltage_gain_q8 <= VOLTAGE_GAIN_RST;
      cfg_r.current_zero_mv <= CURRENT_ZERO_RST;
      cfg_r.current_gain_q8 <= CURRENT_GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/tcrms_ring.sv
// ----------------------------------------------------------------------------
// tcrms_ring
// Sample rings of both channels in one memory; per-entry valid bits make
// unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module tcrms_ring import tcrms_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ring_req_t                  req,
  output logic signed [SCALED_W-1:0] old_value
);

  logic signed [SCALED_W-1:0] mem [RING_DEPTH];
  logic [RING_DEPTH-1:0]      vld_r;
  logic signed [SCALED_W-1:0] rd_data_r;
  logic                       rd_vld_r;
  logic [RING_AW-1:0]         addr;

  // current channel sits in the upper half
  assign addr = req.ch ? RING_AW'(WINDOW_LENGTH) + RING_AW'(req.pos) : RING_AW'(req.pos);

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  assign old_value = rd_vld_r ? rd_data_r : '0;

endmodule

>>> rtl/tcrms_core.sv
// ----------------------------------------------------------------------------
// tcrms_core
// Sequencer and datapath: shared multiplier for scaling and squares, running
// sums, radix-256 divide by the window, bit-serial square root.
// ----------------------------------------------------------------------------
module tcrms_core import tcrms_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  tcrms_in_if.sink                   in_chan,
  tcrms_out_if.source                out_chan,
  output ring_req_t                  ring_req,
  input  logic signed [SCALED_W-1:0] old_value
);

  core_state_t state_r, state_nxt;

  logic                       ch_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SCALED_W-1:0] scaled_r;
  logic [DIV_PAD_W-1:0]       acc_r;
  logic [REM_W-1:0]           rem_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [SUM_W-1:0]           root_r;
  logic [SUM_W-1:0]           bit_r;
  logic [SUM_W-1:0]           sum_r [2];
  logic [POS_W-1:0]           pos_r [2];

  logic                       out_valid_r;
  logic                       out_ch_r;
  logic signed [SCALED_W-1:0] out_scaled_r;
  logic [RMS_W-1:0]           out_rms_r;

  logic                       accept;
  logic                       out_free;
  logic                       load_out;
  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   shifted;
  logic signed [SCALED_W-1:0] scaled_sat;
  logic [GAIN_W-1:0]          gain;
  logic signed [DIFF_W-1:0]   diff_in;
  logic [SUM_W-1:0]           sum_new;
  logic [DIV_PAD_W-1:0]       div_q;
  logic [REM_W-1:0]           div_rem;
  logic [SUM_W-1:0]           sq_x;
  logic [SUM_W-1:0]           sq_trial;
  logic                       sq_ge;
  logic [POS_W-1:0]           pos_inc;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_chan.valid) state_nxt = S_SCALE;
      S_SCALE:  state_nxt = S_SAT;
      S_SAT:    state_nxt = S_SQ_NEW;
      S_SQ_NEW: state_nxt = S_ACC;
      S_ACC:    state_nxt = S_DIV;
      S_DIV:    if (cnt_r == CNT_W'(DIV_CYCLES - 1)) state_nxt = S_SQRT;
      S_SQRT:   if (bit_r[0]) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---- outputs / control ----
  always_comb begin
    in_chan.ready    = 1'b0;
    load_out         = 1'b0;
    ring_req.rd_en   = 1'b0;
    ring_req.wr_en   = 1'b0;
    ring_req.ch      = ch_r;
    ring_req.pos     = pos_r[ch_r];
    ring_req.wr_data = scaled_sat;
    mul_a            = old_value;
    mul_b            = old_value;
    unique case (state_r)
      S_IDLE: begin
        in_chan.ready  = 1'b1;
        ring_req.rd_en = in_chan.valid;
        ring_req.ch    = in_chan.channel;
        ring_req.pos   = pos_r[in_chan.channel];
      end
      S_SCALE: begin
        mul_a = {{(MUL_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r};
        mul_b = {{(MUL_W-GAIN_W){1'b0}}, gain};
      end
      S_SAT: begin
        ring_req.wr_en = 1'b1;
      end
      S_SQ_NEW: begin
        mul_a = scaled_r;
        mul_b = scaled_r;
      end
      S_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // ---- datapath ----
  assign gain = ch_r ? cfg.current_gain_q8 : cfg.voltage_gain_q8;
  assign prod = mul_a * mul_b;

  // voltage is taken as is; current loses its zero offset
  assign diff_in = in_chan.channel ?
                   DIFF_W'($signed({1'b0, in_chan.sample_mv})) -
                   DIFF_W'($signed({1'b0, cfg.current_zero_mv})) :
                   DIFF_W'($signed({1'b0, in_chan.sample_mv}));

  // arithmetic shift is floor division by 256
  assign shifted = prod_r >>> FRAC_W;
  always_comb begin
    if (shifted > SAT_HI)      scaled_sat = SAT_HI[SCALED_W-1:0];
    else if (shifted < SAT_LO) scaled_sat = SAT_LO[SCALED_W-1:0];
    else                       scaled_sat = shifted[SCALED_W-1:0];
  end

  // squares are non-negative and below 2^41
  assign sum_new = acc_r[SUM_W-1:0] + SUM_W'(unsigned'(prod_r));

  assign pos_inc = (pos_r[ch_r] == POS_W'(WINDOW_LENGTH - 1)) ? '0 : pos_r[ch_r] + 1'b1;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    div_q   = acc_r;
    div_rem = rem_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      div_rem = (div_rem << 1) | REM_W'(div_q[DIV_PAD_W-1]);
      div_q   = div_q << 1;
      if (div_rem >= REM_W'(WINDOW_LENGTH)) begin
        div_rem  = div_rem - REM_W'(WINDOW_LENGTH);
        div_q[0] = 1'b1;
      end
    end
  end

  // root and bit never overlap, so OR stands in for the add
  assign sq_x     = acc_r[SUM_W-1:0];
  assign sq_trial = root_r | bit_r;
  assign sq_ge    = sq_x >= sq_trial;

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ch_r   <= in_chan.channel;
          diff_r <= diff_in;
        end
      end
      S_SCALE: prod_r <= prod;
      S_SAT: begin
        scaled_r <= scaled_sat;
        prod_r   <= prod;
      end
      S_SQ_NEW: begin
        acc_r  <= DIV_PAD_W'(sum_r[ch_r] - SUM_W'(unsigned'(prod_r)));
        prod_r <= prod;
      end
      S_ACC: begin
        acc_r <= DIV_PAD_W'(sum_new);
        rem_r <= '0;
      end
      S_DIV: begin
        acc_r  <= div_q;
        rem_r  <= div_rem;
        root_r <= '0;
        bit_r  <= SUM_W'(1) << (SUM_W - 2);
      end
      S_SQRT: begin
        if (sq_ge) begin
          acc_r  <= DIV_PAD_W'(sq_x - sq_trial);
          root_r <= (root_r >> 1) | bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: ;
    endcase
    if (load_out) begin
      out_ch_r     <= ch_r;
      out_scaled_r <= scaled_r;
      out_rms_r    <= (|root_r[SUM_W-1:RMS_W]) ? '1 : root_r[RMS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ACC) begin
        sum_r[ch_r] <= sum_new;
        pos_r[ch_r] <= pos_inc;
        cnt_r       <= '0;
      end else if (state_r == S_DIV) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.channel_out  = out_ch_r;
  assign out_chan.scaled_value = out_scaled_r;
  assign out_chan.rms_value    = out_rms_r;

endmodule

>>> bench/two_channel_sliding_rms_meter_tb.sv
// ----------------------------------------------------------------------------
// two_channel_sliding_rms_meter_tb
// Self-checking bench for the two-channel sliding-window RMS meter. Samples
// go in on a valid/ready channel from a queue, and each accepted sample is
// run through a bit-accurate predictor of scaling, ring, square sum and
// floor root. Result items are checked in order, field by field. The run
// walks through several register settings, extremes among them, and adds
// random idling on both sides, a long output hold-off and drained pauses.
// ----------------------------------------------------------------------------
module two_channel_sliding_rms_meter_tb import tcrms_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       CH_VOLTAGE       = 1'b0;
  localparam logic       CH_CURRENT       = 1'b1;
  localparam logic [1:0] REG_UNUSED       = 2'd3;  // decodes to nothing, write is dropped
  localparam longint     SCALED_HI        = (64'sd1 <<< (SCALED_W - 1)) - 1;
  localparam longint     SCALED_LO        = -SCALED_HI - 1;
  localparam longint     RMS_HI           = (64'sd1 <<< RMS_W) - 1;
  localparam int         SAMPLE_MAX       = (1 << SAMPLE_W) - 1;
  localparam int         LONG_HOLD_CYCLES = 300;
  localparam int         SETTLE_CYCLES    = 40;   // a bit above the time one item takes
  localparam int         RANDOM_PHASES    = 8;
  localparam int         CHUNKS           = 3;
  localparam int         CHUNK_ITEMS      = 77;

  typedef struct {
    logic                channel;
    logic [SAMPLE_W-1:0] sample_mv;
  } sample_item_t;

  typedef struct {
    logic                       channel;
    logic signed [SCALED_W-1:0] scaled;
    logic [RMS_W-1:0]           rms;
  } rms_reading_t;

  logic clk;
  logic rst_n;

  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  tcrms_in_if  in_if ();
  tcrms_out_if out_if ();

  two_channel_sliding_rms_meter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Samples not yet accepted, and readings accepted but not yet seen
  sample_item_t pending_samples[$];
  rms_reading_t expected_readings[$];

  // Predictor copy of the registers and per-channel window state
  logic [GAIN_W-1:0]          voltage_gain = VOLTAGE_GAIN_RST;
  logic [ZERO_W-1:0]          current_zero = CURRENT_ZERO_RST;
  logic [GAIN_W-1:0]          current_gain = CURRENT_GAIN_RST;
  logic signed [SCALED_W-1:0] window_ring [2][WINDOW_LENGTH];
  int                         write_pos [2];
  logic [SUM_W-1:0]           square_sum [2];

  // Idling knobs, set per phase by the sequencer
  int in_gap_max    = 0;
  int out_stall_max = 0;
  int in_gap        = 0;
  int out_stall     = 0;
  int out_hold      = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int failures      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: scale one sample, slide it into its channel window and work
  // out the reading the block must return for it.
  // --------------------------------------------------------------------------
  function automatic rms_reading_t scale_and_track(input logic ch,
                                                   input logic [SAMPLE_W-1:0] mv);
    longint            product;
    longint            scaled;
    longint            old_v;
    longint unsigned   mean_sq;
    longint unsigned   root;
    longint unsigned   bitv;
    rms_reading_t      r;
    int                c;
    c = int'(ch);
    if (ch == CH_VOLTAGE) begin
      product = longint'(mv) * longint'(voltage_gain);
    end else begin
      // signed offset from the sensor zero, then mA gain
      product = (longint'(mv) - longint'(current_zero)) * longint'(current_gain);
    end
    scaled = product >>> 8;  // arithmetic shift floors toward minus infinity
    if (scaled > SCALED_HI) scaled = SCALED_HI;
    if (scaled < SCALED_LO) scaled = SCALED_LO;

    if (write_pos[c] >= WINDOW_LENGTH) write_pos[c] = 0;
    old_v = longint'(window_ring[c][write_pos[c]]);
    square_sum[c] = SUM_W'(square_sum[c] - longint'(old_v * old_v)
                           + longint'(scaled * scaled));
    window_ring[c][write_pos[c]] = SCALED_W'(scaled);
    write_pos[c] = (write_pos[c] + 1 >= WINDOW_LENGTH) ? 0 : write_pos[c] + 1;

    // cleared entries count as zero; divisor is always the full window
    mean_sq = longint'(square_sum[c]) / WINDOW_LENGTH;
    root    = 0;
    bitv    = 64'd1 << 62;
    while (bitv > mean_sq) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (mean_sq >= root + bitv) begin
        mean_sq = mean_sq - (root + bitv);
        root    = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (root > RMS_HI) root = RMS_HI;

    r.channel = ch;
    r.scaled  = SCALED_W'(scaled);
    r.rms     = RMS_W'(root);
    return r;
  endfunction

  task automatic queue_sample(input logic ch, input int mv);
    sample_item_t s;
    s.channel   = ch;
    s.sample_mv = SAMPLE_W'(mv);
    pending_samples.push_back(s);
  endtask

  // Wait until every queued sample went in and every reading came out,
  // then give the core time to fall idle.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, done at the edge with pready high
  task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // upper data bits are dropped by the register width
    case (idx)
      REG_VOLTAGE_GAIN: voltage_gain = value[GAIN_W-1:0];
      REG_CURRENT_ZERO: current_zero = value[ZERO_W-1:0];
      REG_CURRENT_GAIN: current_gain = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offers the head of the pending queue, holds it until taken,
  // then idles a random number of cycles before the next item.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_readings.push_back(scale_and_track(in_if.channel, in_if.sample_mv));
        void'(pending_samples.pop_front());
        in_gap = $urandom_range(0, in_gap_max);
      end
      // an offered item that was not taken stays on the bus unchanged
      if (!(in_if.valid && !in_if.ready)) begin
        if (in_gap > 0 || pending_samples.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid     <= 1'b1;
          in_if.channel   <= pending_samples[0].channel;
          in_if.sample_mv <= pending_samples[0].sample_mv;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: checks each taken item against the oldest prediction and
  // drives ready with random stalls and the occasional long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rms_reading_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        out_hold    = LONG_HOLD_CYCLES;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected item: channel_out %0d scaled_value %0d rms_value %0d",
                 out_if.channel_out, out_if.scaled_value, out_if.rms_value);
          failures++;
        end else begin
          want = expected_readings.pop_front();
          if (out_if.channel_out !== want.channel) begin
            $error("channel_out: expected %0d, actual %0d", want.channel, out_if.channel_out);
            failures++;
          end
          if (out_if.scaled_value !== want.scaled) begin
            $error("scaled_value: expected %0d, actual %0d", want.scaled, out_if.scaled_value);
            failures++;
          end
          if (out_if.rms_value !== want.rms) begin
            $error("rms_value: expected %0d, actual %0d", want.rms, out_if.rms_value);
            failures++;
          end
        end
        out_stall = $urandom_range(0, out_stall_max);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_if.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: reset, directed items, then random phases under varied
  // register settings and idling.
  // --------------------------------------------------------------------------
  initial begin
    int mv;
    int bias;
    int pick;
    logic ch;
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < WINDOW_LENGTH; k++) window_ring[c][k] = '0;
      write_pos[c]  = 0;
      square_sum[c] = '0;
    end
    in_if.valid     = 1'b0;
    in_if.channel   = CH_VOLTAGE;
    in_if.sample_mv = '0;
    out_if.ready    = 1'b0;
    rst_n           = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: range ends, the current zero point and just around it.
    // First items also see a window still full of cleared entries.
    @(negedge clk);
    queue_sample(CH_VOLTAGE, 0);
    queue_sample(CH_VOLTAGE, SAMPLE_MAX);
    queue_sample(CH_VOLTAGE, 1);
    queue_sample(CH_VOLTAGE, 2048);
    queue_sample(CH_CURRENT, 0);
    queue_sample(CH_CURRENT, SAMPLE_MAX);
    queue_sample(CH_CURRENT, 1650);
    queue_sample(CH_CURRENT, 1649);
    queue_sample(CH_CURRENT, 1651);
    wait_drained();

    // Max gains, zero offset at 0: largest positive values. Junk in the
    // upper data bits must be dropped; a write to the unused slot ignored.
    write_register(REG_VOLTAGE_GAIN, 32'hFFFF_FFFF);
    write_register(REG_CURRENT_ZERO, 32'h5A5A_F000);
    write_register(REG_CURRENT_GAIN, 32'hABCD_FFFF);
    write_register(REG_UNUSED, $urandom());
    @(negedge clk);
    queue_sample(CH_VOLTAGE, SAMPLE_MAX);
    queue_sample(CH_CURRENT, SAMPLE_MAX);
    queue_sample(CH_CURRENT, 0);
    wait_drained();

    // Zero offset at its top: most negative current
    write_register(REG_CURRENT_ZERO, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_sample(CH_CURRENT, 0);
    queue_sample(CH_CURRENT, SAMPLE_MAX);
    wait_drained();

    // Zero gains
    write_register(REG_VOLTAGE_GAIN, 32'h0);
    write_register(REG_CURRENT_GAIN, 32'h0);
    @(negedge clk);
    queue_sample(CH_VOLTAGE, SAMPLE_MAX);
    queue_sample(CH_CURRENT, 0);
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_register(REG_VOLTAGE_GAIN, 32'(VOLTAGE_GAIN_RST));
          write_register(REG_CURRENT_ZERO, 32'(CURRENT_ZERO_RST));
          write_register(REG_CURRENT_GAIN, 32'(CURRENT_GAIN_RST));
        end
        1: begin
          write_register(REG_VOLTAGE_GAIN, 32'hFFFF);
          write_register(REG_CURRENT_ZERO, 32'h0);
          write_register(REG_CURRENT_GAIN, 32'hFFFF);
        end
        2: begin
          write_register(REG_VOLTAGE_GAIN, 32'hFFFF);
          write_register(REG_CURRENT_ZERO, 32'hFFF);
          write_register(REG_CURRENT_GAIN, 32'hFFFF);
        end
        3: begin
          // small gains keep readings near the bottom of the range
          write_register(REG_VOLTAGE_GAIN, $urandom_range(0, 255));
          write_register(REG_CURRENT_ZERO, $urandom_range(0, SAMPLE_MAX));
          write_register(REG_CURRENT_GAIN, $urandom_range(0, 255));
        end
        default: begin
          write_register(REG_VOLTAGE_GAIN, $urandom());
          write_register(REG_CURRENT_ZERO, $urandom());
          write_register(REG_CURRENT_GAIN, $urandom());
        end
      endcase
      // some phases run with no idling on one or both sides
      in_gap_max    = (phase == 2 || phase == 5) ? 0 : 16;
      out_stall_max = (phase == 2 || phase == 6) ? 0 : 16;

      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        @(negedge clk);
        // hold off the receiver while samples keep coming, so the block
        // fills up and has to stall its input
        if (phase == 3 && chunk == 1) hold_requests++;
        bias = $urandom_range(0, 2);
        for (int n = 0; n < CHUNK_ITEMS; n++) begin
          case (bias)
            0:       ch = 1'($urandom_range(0, 1));
            1:       ch = ($urandom_range(0, 9) < 8) ? CH_VOLTAGE : CH_CURRENT;
            default: ch = ($urandom_range(0, 9) < 8) ? CH_CURRENT : CH_VOLTAGE;
          endcase
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            mv = $urandom_range(0, SAMPLE_MAX);
          end else if (pick < 8) begin
            mv = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
          end else begin
            // near the zero point: sign changes of the current offset
            mv = int'(current_zero) + int'($urandom_range(0, 6)) - 3;
            if (mv < 0) mv = 0;
            if (mv > SAMPLE_MAX) mv = SAMPLE_MAX;
          end
          queue_sample(ch, mv);
        end
        // sender pauses here until every reading is back
        wait_drained();
      end
    end

    repeat (50) @(posedge clk);
    if (expected_readings.size() != 0) begin
      $error("%0d readings never arrived", expected_readings.size());
      failures++;
    end
    if (failures == 0) begin
      $display("two_channel_sliding_rms_meter verification clean");
    end else begin
      $display("two_channel_sliding_rms_meter verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #(8_000_000);
    $display("two_channel_sliding_rms_meter verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/tcrms_pkg.sv
rtl/tcrms_if.sv
rtl/tcrms_cfg_regs.sv
rtl/tcrms_ring.sv
rtl/tcrms_core.sv
rtl/two_channel_sliding_rms_meter.sv
bench/two_channel_sliding_rms_meter_tb.sv
